// ----- rtl/dct_pkg.sv -----
// dct_pkg: shared types, codes and register addresses for device_command_tracker.
// No dependencies.
package dct_pkg;
  localparam int MaxDevicesDefault = 16;

  localparam logic [1:0] ACT_ADD  = 2'd0;
  localparam logic [1:0] ACT_SEND = 2'd1;
  localparam logic [1:0] ACT_RESP = 2'd2;
  localparam logic [1:0] ACT_TICK = 2'd3;

  localparam logic [2:0] KIND_ACK  = 3'd0;
  localparam logic [2:0] KIND_TX   = 3'd1;
  localparam logic [2:0] KIND_HOST = 3'd2;
  localparam logic [2:0] KIND_OFF  = 3'd3;
  localparam logic [2:0] KIND_END  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_STANDBY = 2'd1;
  localparam logic [1:0] PH_RUN     = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic [2:0] REG_HB_INT   = 3'd0;
  localparam logic [2:0] REG_CMD_TO   = 3'd1;
  localparam logic [2:0] REG_HB_RETRY = 3'd2;
  localparam logic [2:0] REG_MAX_RTY  = 3'd3;
  localparam logic [2:0] REG_DEF_CH   = 3'd4;
  localparam logic [2:0] REG_HB_CODE  = 3'd5;
  localparam logic [2:0] REG_AB_CODE  = 3'd6;
  localparam logic [2:0] REG_MR_CODE  = 3'd7;

  typedef struct packed {
    logic [31:0] hb_interval;
    logic [31:0] cmd_retry_wait;
    logic [31:0] hb_retry_wait;
    logic [7:0]  max_retries;
    logic [7:0]  def_channel;
    logic [7:0]  hb_code;
    logic [7:0]  ab_code;
    logic [7:0]  mr_code;
  } cfg_t;

  // one table entry
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  channel;
    logic [7:0]  command;
    logic [31:0] tag;
    logic [7:0]  reply;
    logic [1:0]  phase;
    logic [7:0]  retries;
    logic [31:0] stamp;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic       latch_in;  // capture accepted word
    logic       rd;        // fetch entry at index
    logic       eval;      // process fetched entry (act per action)
    logic       shift;     // move entry idx+1 down to idx
    logic       append;    // write new entry at count
    logic       emit_ack;  // emit ack for add/send
    logic       emit_end;  // emit scan end
  } dct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       hit;       // fetched entry id matches
    logic       removed;   // eval removed the entry
    logic       at_end;    // index reached count
    logic       shift_done;
    logic       full;
    logic       found;     // search hit an entry for this word
  } dct_stat_t;
endpackage

// ----- rtl/dct_datapath.sv -----
// dct_datapath: entry memory, scan index, per-entry evaluation and result register.
// Depends on dct_pkg.
module dct_datapath import dct_pkg::*; #(
  parameter int MaxDevices = MaxDevicesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  dct_cmd_t    cmd,
  output dct_stat_t   stat,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_device_id,
  input  logic [7:0]  in_command,
  input  logic [31:0] in_tag,
  input  logic [7:0]  in_reply,
  input  logic [31:0] in_now_time,
  input  logic        in_link_ready,
  input  logic        in_host_ready,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_out_id,
  output logic [7:0]  out_out_channel,
  output logic [7:0]  out_out_command,
  output logic [31:0] out_out_tag,
  output logic [7:0]  out_out_reply,
  output logic        out_last
);
  localparam int IW = (MaxDevices > 1) ? $clog2(MaxDevices) : 1;
  localparam int CW = $clog2(MaxDevices + 1);

  entry_t      mem [MaxDevices];
  entry_t      ent_r;
  logic [CW-1:0] idx_r, cnt_r, scan_r;
  logic [1:0]  act_r;
  logic [15:0] id_r;
  logic [7:0]  cmd_r, rep_r;
  logic [31:0] tag_r, now_r;
  logic        link_r, host_r, found_r;

  logic [IW-1:0] ix, ix1;
  assign ix  = idx_r[IW-1:0];
  assign ix1 = IW'(idx_r + CW'(1));

  // evaluation of fetched entry
  entry_t      ent_nxt;
  logic        wr_ent, rm, emit;
  logic [2:0]  ekind;
  logic [31:0] elapsed, limit;
  logic [7:0]  rty_inc;
  logic        id_hit;

  assign id_hit  = ent_r.id == id_r;
  assign elapsed = now_r - ent_r.stamp;
  assign limit   = (ent_r.command != cfg.hb_code) ? cfg.cmd_retry_wait : cfg.hb_retry_wait;
  assign rty_inc = ent_r.retries + 8'd1;

  always_comb begin
    ent_nxt = ent_r;
    wr_ent  = 1'b0;
    rm      = 1'b0;
    emit    = 1'b0;
    ekind   = KIND_TX;
    unique case (act_r)
      ACT_SEND: begin
        if (id_hit && ent_r.phase == PH_IDLE) begin
          ent_nxt.command = cmd_r;
          ent_nxt.tag     = tag_r;
          ent_nxt.reply   = 8'd0;
          ent_nxt.phase   = PH_STANDBY;
          wr_ent = 1'b1;
        end
      end
      ACT_RESP: begin
        if (id_hit) begin
          if (ent_r.command == cmd_r && ent_r.tag == tag_r) begin
            ent_nxt.reply = rep_r;
            ent_nxt.phase = PH_DONE;
            wr_ent = 1'b1;
          end else if (cmd_r == cfg.ab_code && tag_r == 32'd0) begin
            ent_nxt.command = cmd_r;
            ent_nxt.reply   = rep_r;
            ent_nxt.phase   = PH_DONE;
            wr_ent = 1'b1;
          end
        end
      end
      ACT_TICK: begin
        unique case (ent_r.phase)
          PH_IDLE: if (elapsed > cfg.hb_interval) begin
            ent_nxt.phase   = PH_STANDBY;
            ent_nxt.command = cfg.hb_code;
            ent_nxt.reply   = 8'd0;
            ent_nxt.tag     = 32'd0;
            wr_ent = 1'b1;
          end
          PH_STANDBY: if (link_r) begin
            emit  = 1'b1;
            ekind = KIND_TX;
            ent_nxt.phase = PH_RUN;
            ent_nxt.stamp = now_r;
            wr_ent = 1'b1;
          end
          PH_RUN: if (elapsed >= limit) begin
            ent_nxt.phase   = PH_STANDBY;
            ent_nxt.retries = rty_inc;
            wr_ent = 1'b1;
            if (rty_inc >= cfg.max_retries) begin
              rm     = 1'b1;
              wr_ent = 1'b0;
              emit   = 1'b1;
              ekind  = KIND_OFF;
            end
          end
          default: begin
            ent_nxt.stamp = now_r;
            wr_ent = 1'b1;
            if (ent_r.command != cfg.hb_code) begin
              if (host_r) begin
                emit  = 1'b1;
                ekind = KIND_HOST;
                ent_nxt.retries = 8'd0;
                if (ent_r.reply == cfg.mr_code) ent_nxt.phase = PH_RUN;
                else begin
                  ent_nxt.phase = PH_IDLE; ent_nxt.tag = 32'd0;
                  ent_nxt.command = 8'd0;  ent_nxt.reply = 8'd0;
                end
              end
            end else begin
              ent_nxt.phase = PH_IDLE; ent_nxt.tag = 32'd0;
              ent_nxt.command = 8'd0;  ent_nxt.reply = 8'd0;
              ent_nxt.retries = 8'd0;
            end
          end
        endcase
      end
      default: ;
    endcase
  end

  assign stat.hit        = id_hit;
  assign stat.removed    = rm;
  assign stat.at_end     = idx_r >= cnt_r;
  assign stat.shift_done = (idx_r + CW'(1)) >= cnt_r;
  assign stat.full       = cnt_r >= CW'(MaxDevices);
  assign stat.found      = found_r;

  entry_t new_ent;
  always_comb begin
    new_ent = '0;
    new_ent.id      = id_r;
    new_ent.channel = cfg.def_channel;
  end

  // entry memory: one write port, registered read
  always_ff @(posedge clk) begin
    if (cmd.append) mem[cnt_r[IW-1:0]] <= new_ent;
    else if (cmd.shift) mem[ix] <= mem[ix1];
    else if (cmd.eval && wr_ent) mem[ix] <= ent_nxt;
    if (cmd.rd) ent_r <= mem[ix];
  end

  // removal: idx walks the tail as shift pointer, then returns to the
  // removed slot so the entry moved into it is scanned next
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      cnt_r     <= '0;
      scan_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cmd.eval && rm) scan_r <= idx_r;
      if (cmd.latch_in) idx_r <= '0;
      else if (cmd.shift && stat.shift_done) idx_r <= cmd.eval ? idx_r : scan_r;
      else if (cmd.shift) idx_r <= idx_r + CW'(1);
      else if (cmd.eval) idx_r <= idx_r + CW'(1);
      if (cmd.append) cnt_r <= cnt_r + CW'(1);
      if (cmd.shift && stat.shift_done) cnt_r <= cnt_r - CW'(1);
      if (cmd.eval && act_r == ACT_TICK && emit) out_valid <= 1'b1;
      if (cmd.emit_ack || cmd.emit_end) out_valid <= 1'b1;
    end
  end

  // capture word and found flag
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r <= in_action; id_r <= in_device_id; cmd_r <= in_command;
      tag_r <= in_tag; rep_r <= in_reply; now_r <= in_now_time;
      link_r <= in_link_ready; host_r <= in_host_ready;
      found_r <= 1'b0;
    end else if (cmd.eval && act_r != ACT_TICK && id_hit && !found_r) begin
      found_r <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.eval && act_r == ACT_TICK) begin
      out_kind        <= ekind;
      out_status      <= ST_OK;
      out_out_id      <= ent_r.id;
      out_out_channel <= (ekind == KIND_TX) ? ent_r.channel : 8'd0;
      out_out_command <= (ekind == KIND_OFF) ? 8'd0 : ent_r.command;
      out_out_tag     <= (ekind == KIND_OFF) ? 32'd0 : ent_r.tag;
      out_out_reply   <= (ekind == KIND_HOST) ? ent_r.reply : 8'd0;
      out_last        <= 1'b0;
    end else if (cmd.emit_ack) begin
      out_kind        <= KIND_ACK;
      out_out_id      <= id_r;
      out_out_channel <= 8'd0;
      out_out_command <= 8'd0;
      out_out_reply   <= 8'd0;
      out_out_tag     <= 32'd0;
      out_last        <= 1'b1;
      // ent_r still holds the matched entry as it was before the send
      if (act_r == ACT_ADD) out_status <= (!found_r && stat.full) ? ST_FULL : ST_OK;
      else if (!found_r) out_status <= ST_NOTFOUND;
      else if (ent_r.phase != PH_IDLE) begin
        out_status <= ST_BUSY;
        out_out_tag <= tag_r;
      end else out_status <= ST_OK;
    end else if (cmd.emit_end) begin
      out_kind <= KIND_END; out_status <= ST_OK; out_out_id <= 16'd0;
      out_out_channel <= 8'd0; out_out_command <= 8'd0; out_out_tag <= 32'd0;
      out_out_reply <= 8'd0; out_last <= 1'b1;
    end
  end
endmodule

// ----- rtl/dct_ctrl.sv -----
// dct_ctrl: sequencer for add, send, response and tick scan.
// Depends on dct_pkg.
module dct_ctrl import dct_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_action,
  input  dct_stat_t  stat,
  output dct_cmd_t   cmd,
  output logic       busy
);
  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_EVAL, S_SHIFT, S_FIN, S_ACK
  } state_t;

  state_t     state_r;
  logic [1:0] act_r;

  always_comb begin
    cmd = '0;
    busy = state_r != S_IDLE;
    unique case (state_r)
      S_IDLE:  cmd.latch_in = start;
      S_FETCH: cmd.rd = !stat.at_end;
      S_EVAL:  begin
        cmd.eval  = 1'b1;
        cmd.shift = stat.removed;
      end
      S_SHIFT: cmd.shift = 1'b1;
      S_FIN: begin
        cmd.append   = act_r == ACT_ADD && !stat.found && !stat.full;
        cmd.emit_ack = act_r == ACT_ADD || act_r == ACT_SEND;
        cmd.emit_end = act_r == ACT_TICK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r   <= ACT_ADD;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) begin
          act_r <= in_action;
          state_r <= S_FETCH;
        end
        S_FETCH: state_r <= stat.at_end ? S_FIN : S_EVAL;
        S_EVAL: begin
          if (stat.removed) state_r <= stat.shift_done ? S_FETCH : S_SHIFT;
          else if (act_r != ACT_TICK && stat.hit) state_r <= S_ACK;
          else state_r <= S_FETCH;
        end
        S_SHIFT: if (stat.shift_done) state_r <= S_FETCH;
        S_ACK: state_r <= S_FIN;
        S_FIN: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- rtl/device_command_tracker.sv -----
// device_command_tracker: table of remote devices with one command slot each.
// Add/send: entries are searched in turn up to a hit or the end, then an ack strobe; a
// response likewise without strobe. Tick: all entries are evaluated, then scan end; a
// removal shifts the tail. One word at a time; busy from accept through the last strobe.
// Synchronous active-low reset clears the table and loads register defaults;
// results cannot be stalled by the receiver. Depends on dct_pkg, dct_ctrl, dct_datapath.
module device_command_tracker import dct_pkg::*; #(
  parameter int MaxDevices = MaxDevicesDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [15:0] in_device_id,
  input  logic [7:0]  in_command,
  input  logic [31:0] in_tag,
  input  logic [7:0]  in_reply,
  input  logic [31:0] in_now_time,
  input  logic        in_link_ready,
  input  logic        in_host_ready,
  output logic        out_valid,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [15:0] out_out_id,
  output logic [7:0]  out_out_channel,
  output logic [7:0]  out_out_command,
  output logic [31:0] out_out_tag,
  output logic [7:0]  out_out_reply,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  cfg_t      cfg_r;
  dct_cmd_t  cmd;
  dct_stat_t stat;
  logic      busy_c;
  logic [2:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[4:2];

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hb_interval    <= 32'd60;
      cfg_r.cmd_retry_wait <= 32'd10;
      cfg_r.hb_retry_wait  <= 32'd5;
      cfg_r.max_retries    <= 8'd3;
      cfg_r.def_channel    <= 8'd0;
      cfg_r.hb_code        <= 8'd1;
      cfg_r.ab_code        <= 8'd2;
      cfg_r.mr_code        <= 8'd3;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_HB_INT:   cfg_r.hb_interval    <= pwdata;
        REG_CMD_TO:   cfg_r.cmd_retry_wait <= pwdata;
        REG_HB_RETRY: cfg_r.hb_retry_wait  <= pwdata;
        REG_MAX_RTY:  cfg_r.max_retries    <= pwdata[7:0];
        REG_DEF_CH:   cfg_r.def_channel    <= pwdata[7:0];
        REG_HB_CODE:  cfg_r.hb_code        <= pwdata[7:0];
        REG_AB_CODE:  cfg_r.ab_code        <= pwdata[7:0];
        default:      cfg_r.mr_code        <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_HB_INT:   prdata = cfg_r.hb_interval;
      REG_CMD_TO:   prdata = cfg_r.cmd_retry_wait;
      REG_HB_RETRY: prdata = cfg_r.hb_retry_wait;
      REG_MAX_RTY:  prdata = {24'd0, cfg_r.max_retries};
      REG_DEF_CH:   prdata = {24'd0, cfg_r.def_channel};
      REG_HB_CODE:  prdata = {24'd0, cfg_r.hb_code};
      REG_AB_CODE:  prdata = {24'd0, cfg_r.ab_code};
      default:      prdata = {24'd0, cfg_r.mr_code};
    endcase
  end

  // busy also covers the final result strobe
  assign busy = busy_c || out_valid;

  dct_ctrl u_ctrl (
    .clk, .rst_n, .start(start && !busy), .in_action, .stat, .cmd, .busy(busy_c)
  );

  dct_datapath #(.MaxDevices(MaxDevices)) u_dp (
    .clk, .rst_n, .cfg(cfg_r), .cmd, .stat,
    .in_action, .in_device_id, .in_command, .in_tag, .in_reply, .in_now_time,
    .in_link_ready, .in_host_ready,
    .out_valid, .out_kind, .out_status, .out_out_id, .out_out_channel,
    .out_out_command, .out_out_tag, .out_out_reply, .out_last
  );
endmodule
